// ----- rtl/ppe_pkg.sv -----
package ppe_pkg;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_SCAN   = 3'd1;
  localparam logic [2:0] OP_FINAL  = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_ENCODE = 3'd4;

  localparam int MAP_ROWS   = 4096;
  localparam int MAP_ROW_W  = 12;
  localparam logic [23:0] KEY_BASE = 24'hff00ff;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [8:0] entry_index;
  } ppe_in_t;

  typedef struct packed {
    logic [15:0] code;
    logic [23:0] entry_color;
    logic        direct_mode;
    logic        has_transparency;
    logic [15:0] key_value;
    logic [8:0]  entry_count;
    logic        failed;
  } ppe_out_t;

  typedef enum logic [15:0] {
    S_WIPE  = 16'b0000_0000_0000_0001,
    S_IDLE  = 16'b0000_0000_0000_0010,
    S_ARITH = 16'b0000_0000_0000_0100,
    S_MAPRD = 16'b0000_0000_0000_1000,
    S_MAPWR = 16'b0000_0000_0001_0000,
    S_SRD   = 16'b0000_0000_0010_0000,
    S_SCMP  = 16'b0000_0000_0100_0000,
    S_HCMP  = 16'b0000_0000_1000_0000,
    S_SHRD  = 16'b0000_0001_0000_0000,
    S_SHWR  = 16'b0000_0010_0000_0000,
    S_INS   = 16'b0000_0100_0000_0000,
    S_KRD   = 16'b0000_1000_0000_0000,
    S_KCHK  = 16'b0001_0000_0000_0000,
    S_PRD   = 16'b0010_0000_0000_0000,
    S_PQ    = 16'b0100_0000_0000_0000,
    S_DONE  = 16'b1000_0000_0000_0000
  } ppe_state_t;

endpackage

// ----- rtl/ppe_ram.sv -----
module ppe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ppe_arith.sv -----
module ppe_arith (
  input  logic [7:0]  x,
  input  logic [7:0]  y,
  input  logic [15:0] k,
  output logic [7:0]  q
);

  logic [15:0] prod;
  logic [16:0] sum;
  logic [16:0] fix;

  // (x*y + k) / 255, exact for sums below 65535
  assign prod = x * y;
  assign sum  = {1'b0, prod} + {1'b0, k};
  assign fix  = sum + {8'd0, sum[16:8]} + 17'd1;
  assign q    = fix[15:8];

endmodule

// ----- rtl/palette_rgb565_pixel_encoder.sv -----
// Palette builder and RGB565 / index encoder for RGBA pixels.
// Input: in_data is taken at a rising edge with start high and busy low.
// Opcodes: clear, scan pixel, finalize, read palette entry, encode pixel.
// Output: exactly one result per transfer, shown on out_data for one cycle
// with out_valid high; the receiver cannot stall, so nothing waits.
// The work per item is set by the single shared blend unit and the
// one-read-port palette and used-map memories:
//   scan: 6 blend steps, a used-map read and write, then a binary
//         search, then palette entries moved one by one for an insertion
//   encode: 3 blend steps and a palette search (indexed) or 6 (direct)
//   finalize: direct key search reads one 16-bit map row at a time;
//         indexed key search runs one palette search per candidate
//   read entry: one palette read; clear: used map wiped row by row
// After reset the block is busy while it wipes the used map and
// then gives no result. busy stays high for the whole of every item.
module palette_rgb565_pixel_encoder #(
  parameter int PALETTE_LIMIT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ppe_pkg::ppe_in_t   in_data,
  output logic               out_valid,
  output ppe_pkg::ppe_out_t  out_data
);
  import ppe_pkg::*;

  localparam int PDEPTH = PALETTE_LIMIT + 1;
  localparam int PAW = $clog2(PDEPTH);
  localparam logic [8:0] LIM = 9'(PALETTE_LIMIT);

  ppe_state_t state_r, state_nxt;
  ppe_in_t    in_r, in_nxt;
  logic [2:0] step_r, step_nxt;
  logic [7:0] cr_r, cr_nxt, cg_r, cg_nxt, cb_r, cb_nxt;
  logic [7:0] qr_r, qr_nxt, qg_r, qg_nxt, qb_r, qb_nxt;
  logic [8:0] cnt_r, cnt_nxt, tbl_r, tbl_nxt;
  logic       seen_r, seen_nxt, dir_r, dir_nxt, pend_r, pend_nxt;
  logic [15:0] key_r, key_nxt;
  logic [8:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, ptr_r, ptr_nxt;
  logic [8:0] cand_r, cand_nxt;
  logic [MAP_ROW_W-1:0] row_r, row_nxt;
  logic [15:0] code_r, code_nxt;
  logic [23:0] ecol_r, ecol_nxt;
  logic        fail_r, fail_nxt;

  logic [7:0]  ax, ay, aq;
  logic [15:0] ak;
  logic [7:0]  na;
  logic [15:0] bias;
  logic [15:0] v565;
  logic [23:0] col, tgt;
  logic [8:0]  hi_init, mid_c;
  logic [8:0]  ptr_dec;
  logic [9:0]  mid_sum, fin_sum;
  logic        hit;

  logic              pal_we;
  logic [PAW-1:0]    pal_wa, pal_ra;
  logic [23:0]       pal_wd, pal_q;
  logic              map_we;
  logic [MAP_ROW_W-1:0] map_wa, map_ra;
  logic [15:0]       map_wd, map_q, free_bits;
  logic [3:0]        free_pos;

  ppe_arith u_arith (.x(ax), .y(ay), .k(ak), .q(aq));

  ppe_ram #(.WIDTH(24), .DEPTH(PDEPTH)) u_pal (
    .clk(clk), .wr_en(pal_we), .wr_addr(pal_wa), .wr_data(pal_wd),
    .rd_addr(pal_ra), .rd_data(pal_q)
  );

  ppe_ram #(.WIDTH(16), .DEPTH(MAP_ROWS)) u_map (
    .clk(clk), .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
    .rd_addr(map_ra), .rd_data(map_q)
  );

  assign na   = 8'd255 - in_r.alpha;
  assign bias = ({8'd0, na} << 8) - {8'd0, na} + 16'd127;
  assign col  = {cr_r, cg_r, cb_r};
  assign v565 = {qr_r[4:0], qg_r[5:0], qb_r[4:0]};
  assign tgt  = (in_r.opcode == OP_FINAL) ? (KEY_BASE ^ {15'd0, cand_r}) : col;
  assign hi_init = (cnt_r < LIM) ? cnt_r : LIM;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c   = mid_sum[9:1];
  assign ptr_dec = ptr_r - 9'd1;
  assign fin_sum = {1'b0, cnt_r} + {9'd0, seen_r};
  assign hit = (lo_r < cnt_r) && (lo_r < LIM) && (pal_q == tgt);
  assign free_bits = ~map_q;

  always_comb begin
    free_pos = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_pos = 4'(i);
      end
    end
  end

  // shared blend / quantize operands
  always_comb begin
    ax = 8'd0;
    ay = 8'd31;
    ak = 16'd127;
    case (step_r)
      3'd0: begin ax = in_r.red;   ay = in_r.alpha; ak = bias; end
      3'd1: begin ax = in_r.green; ay = in_r.alpha; ak = bias; end
      3'd2: begin ax = in_r.blue;  ay = in_r.alpha; ak = bias; end
      3'd3: begin ax = cr_r; end
      3'd4: begin ax = cg_r; ay = 8'd63; end
      3'd5: begin ax = cb_r; end
      default: begin ax = 8'd0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    in_nxt = in_r;
    step_nxt = step_r;
    cr_nxt = cr_r; cg_nxt = cg_r; cb_nxt = cb_r;
    qr_nxt = qr_r; qg_nxt = qg_r; qb_nxt = qb_r;
    cnt_nxt = cnt_r; tbl_nxt = tbl_r; seen_nxt = seen_r; dir_nxt = dir_r;
    key_nxt = key_r; pend_nxt = pend_r;
    lo_nxt = lo_r; hi_nxt = hi_r; mid_nxt = mid_r; ptr_nxt = ptr_r;
    cand_nxt = cand_r; row_nxt = row_r;
    code_nxt = code_r; ecol_nxt = ecol_r; fail_nxt = fail_r;
    pal_we = 1'b0; pal_wa = '0; pal_wd = col; pal_ra = '0;
    map_we = 1'b0; map_wa = row_r; map_wd = 16'd0; map_ra = row_r;

    case (state_r)
      S_WIPE: begin
        map_we = 1'b1;
        row_nxt = row_r + 1'b1;
        if (row_r == MAP_ROW_W'(MAP_ROWS - 1)) begin
          state_nxt = pend_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          in_nxt = in_data;
          code_nxt = 16'd0; ecol_nxt = 24'd0; fail_nxt = 1'b0;
          step_nxt = 3'd0;
          lo_nxt = 9'd0;
          hi_nxt = hi_init;
          state_nxt = S_DONE;
          case (in_data.opcode)
            OP_CLEAR: begin
              cnt_nxt = 9'd0; tbl_nxt = 9'd0; seen_nxt = 1'b0; dir_nxt = 1'b0;
              key_nxt = 16'd0; row_nxt = '0; pend_nxt = 1'b1;
              state_nxt = S_WIPE;
            end
            OP_SCAN: begin
              if (in_data.alpha == 8'd0) begin
                seen_nxt = 1'b1;
              end else begin
                state_nxt = S_ARITH;
              end
            end
            OP_FINAL: begin
              dir_nxt = fin_sum > 10'(PALETTE_LIMIT);
              key_nxt = 16'd0;
              if (fin_sum > 10'(PALETTE_LIMIT)) begin
                tbl_nxt = 9'd0;
                row_nxt = '0;
                if (seen_r) state_nxt = S_KRD;
              end else begin
                tbl_nxt = cnt_r;
                cand_nxt = 9'd0;
                if (seen_r) begin
                  key_nxt = {7'd0, cnt_r};
                  state_nxt = S_SRD;
                end
              end
            end
            OP_READ: begin
              if (in_data.entry_index < tbl_r) begin
                state_nxt = S_PRD;
              end else begin
                fail_nxt = 1'b1;
              end
            end
            OP_ENCODE: begin
              if (in_data.alpha == 8'd0 && (seen_r || !dir_r)) begin
                code_nxt = key_r;
              end else begin
                state_nxt = S_ARITH;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_ARITH: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd0: cr_nxt = aq;
          3'd1: cg_nxt = aq;
          3'd2: cb_nxt = aq;
          3'd3: qr_nxt = aq;
          3'd4: qg_nxt = aq;
          default: qb_nxt = aq;
        endcase
        if (step_r == 3'd2 && in_r.opcode == OP_ENCODE && !dir_r) begin
          state_nxt = S_SRD;
        end else if (step_r == 3'd5) begin
          if (in_r.opcode == OP_ENCODE) begin
            code_nxt = {qr_r[4:0], qg_r[5:0], aq[4:0]};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MAPRD;
          end
        end
      end
      S_MAPRD: begin
        map_ra = v565[15:4];
        state_nxt = S_MAPWR;
      end
      S_MAPWR: begin
        map_we = 1'b1;
        map_wa = v565[15:4];
        map_wd = map_q | (16'd1 << v565[3:0]);
        state_nxt = (cnt_r > LIM) ? S_DONE : S_SRD;
      end
      S_SRD: begin
        if (lo_r < hi_r) begin
          pal_ra = mid_c[PAW-1:0];
          mid_nxt = mid_c;
          state_nxt = S_SCMP;
        end else begin
          pal_ra = lo_r[PAW-1:0];
          state_nxt = S_HCMP;
        end
      end
      S_SCMP: begin
        if (pal_q < tgt) begin
          lo_nxt = mid_r + 9'd1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRD;
      end
      S_HCMP: begin
        state_nxt = S_DONE;
        case (in_r.opcode)
          OP_SCAN: begin
            if (!hit) begin
              if (cnt_r >= LIM) begin
                cnt_nxt = LIM + 9'd1;
              end else if (cnt_r == lo_r) begin
                state_nxt = S_INS;
              end else begin
                ptr_nxt = cnt_r;
                state_nxt = S_SHRD;
              end
            end
          end
          OP_ENCODE: begin
            if (hit) begin
              code_nxt = {7'd0, lo_r};
            end else begin
              fail_nxt = 1'b1;
            end
          end
          default: begin
            if (hit) begin
              cand_nxt = cand_r + 9'd1;
              lo_nxt = 9'd0;
              hi_nxt = hi_init;
              state_nxt = S_SRD;
            end else begin
              pal_we = 1'b1;
              pal_wa = cnt_r[PAW-1:0];
              pal_wd = tgt;
              tbl_nxt = cnt_r + 9'd1;
            end
          end
        endcase
      end
      S_SHRD: begin
        pal_ra = ptr_dec[PAW-1:0];
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        pal_we = 1'b1;
        pal_wa = ptr_r[PAW-1:0];
        pal_wd = pal_q;
        ptr_nxt = ptr_dec;
        state_nxt = (ptr_dec == lo_r) ? S_INS : S_SHRD;
      end
      S_INS: begin
        pal_we = 1'b1;
        pal_wa = lo_r[PAW-1:0];
        pal_wd = col;
        cnt_nxt = cnt_r + 9'd1;
        state_nxt = S_DONE;
      end
      S_KRD: begin
        state_nxt = S_KCHK;
      end
      S_KCHK: begin
        if (free_bits != 16'd0) begin
          key_nxt = {row_r, free_pos};
          state_nxt = S_DONE;
        end else if (row_r == MAP_ROW_W'(MAP_ROWS - 1)) begin
          seen_nxt = 1'b0;
          key_nxt = 16'd0;
          state_nxt = S_DONE;
        end else begin
          row_nxt = row_r + 1'b1;
          state_nxt = S_KRD;
        end
      end
      S_PRD: begin
        pal_ra = in_r.entry_index[PAW-1:0];
        state_nxt = S_PQ;
      end
      S_PQ: begin
        ecol_nxt = pal_q;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        pend_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      row_r <= '0;
      pend_r <= 1'b0;
      cnt_r <= 9'd0;
      tbl_r <= 9'd0;
      seen_r <= 1'b0;
      dir_r <= 1'b0;
      key_r <= 16'd0;
    end else begin
      state_r <= state_nxt;
      row_r <= row_nxt;
      pend_r <= pend_nxt;
      cnt_r <= cnt_nxt;
      tbl_r <= tbl_nxt;
      seen_r <= seen_nxt;
      dir_r <= dir_nxt;
      key_r <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
    step_r <= step_nxt;
    cr_r <= cr_nxt; cg_r <= cg_nxt; cb_r <= cb_nxt;
    qr_r <= qr_nxt; qg_r <= qg_nxt; qb_r <= qb_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; mid_r <= mid_nxt; ptr_r <= ptr_nxt;
    cand_r <= cand_nxt;
    code_r <= code_nxt; ecol_r <= ecol_nxt; fail_r <= fail_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data.code = code_r;
  assign out_data.entry_color = ecol_r;
  assign out_data.direct_mode = dir_r;
  assign out_data.has_transparency = seen_r;
  assign out_data.key_value = key_r;
  assign out_data.entry_count = (in_r.opcode == OP_CLEAR || in_r.opcode == OP_SCAN) ?
                                cnt_r : tbl_r;
  assign out_data.failed = fail_r;

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item accepted without going busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LIM + 9'd1) else $error("color count out of range");
  a_tbl_range: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_r <= LIM + 9'd1) else $error("table entries out of range");

endmodule
